### rtl/core/jdcd_pkg.sv
// ----------------------------------------------------------------------------
// jdcd_pkg: shared constants for the Julian date to civil date core
// Field widths, calendar cycle lengths, reciprocal multipliers for the
// constant divisions and the March-based month start table.
// ----------------------------------------------------------------------------
package jdcd_pkg;

   // beat field widths
   localparam int JD_W    = 55;
   localparam int YEAR_W  = 23;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int WDAY_W  = 3;

   // pipeline depth, result register included
   localparam int STAGES = 10;

   // input limit: magnitude strictly below LIMIT_DAYS + 0.99999 days
   localparam logic [63:0] LIMIT_DAYS     = 64'd999999999;
   localparam logic [63:0] LIMIT_FRAC_NUM = 64'd99999;
   localparam logic [63:0] LIMIT_FRAC_DEN = 64'd100000;

   // day count offset and its width once limits hold
   localparam int JDN_OFFSET = 32044;
   localparam int JW         = 30;

   // calendar cycles
   localparam int DAYS_400Y = 146097;
   localparam int DAYS_100Y = 36524;
   localparam int DAYS_4Y   = 1461;
   localparam int DAYS_1Y   = 365;
   localparam int YEARS_400 = 400;
   localparam int YEARS_100 = 100;
   localparam int YEARS_4   = 4;
   localparam int YEAR_BIAS = 4800;

   // internal widths
   localparam int GW   = 13;   // 400-year cycles
   localparam int DGW  = 18;   // day within 400-year cycle
   localparam int CW   = 2;    // century within cycle
   localparam int DCW  = 16;   // day within century
   localparam int BW   = 5;    // 4-year cycle within century
   localparam int DBW  = 11;   // day within 4-year cycle
   localparam int AW   = 2;    // year within 4-year cycle
   localparam int DAW  = 9;    // day within March-based year
   localparam int YW   = 22;   // unbiased year count
   localparam int MIW  = 4;    // March-based month index
   localparam int SPW  = 17;   // seconds of day, 0..86400
   localparam int M60W = 11;   // minutes of day, 0..1440
   localparam int WQW  = 28;   // weekday quotient

   // j / 146097: exact for j < 2**30
   localparam int          G_SHIFT = 48;
   localparam int          G_MW    = 31;
   localparam logic [30:0] G_MULT  =
      31'(((64'd1 << G_SHIFT) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y));

   // day-count weekday: (j + 3) mod 7, 0 is Sunday
   localparam int          WK_OFFSET = 3;
   localparam int          DAYS_WEEK = 7;
   localparam int          WK_SHIFT  = 33;
   localparam int          WK_MW     = 31;
   localparam logic [30:0] WK_MULT   =
      31'(((64'd1 << WK_SHIFT) + 64'(DAYS_WEEK) - 64'd1) / 64'(DAYS_WEEK));

   // dc / 1461: exact for dc < 2**16
   localparam int          B_SHIFT = 27;
   localparam int          B_MW    = 17;
   localparam logic [16:0] B_MULT  =
      17'(((64'd1 << B_SHIFT) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));

   // time of day
   localparam int          SEC_PER_DAY = 86400;
   localparam int          PER_60      = 60;
   localparam int          M60_SHIFT   = 23;   // secs / 60, secs < 2**17
   localparam int          M60_MW      = 18;
   localparam logic [17:0] M60_MULT    =
      18'(((64'd1 << M60_SHIFT) + 64'(PER_60) - 64'd1) / 64'(PER_60));
   localparam int          HR_SHIFT    = 17;   // mins / 60, mins < 2**11
   localparam int          HR_MW       = 12;
   localparam logic [11:0] HR_MULT     =
      12'(((64'd1 << HR_SHIFT) + 64'(PER_60) - 64'd1) / 64'(PER_60));

   // March-based months: index of January, number of March
   localparam int MONTHS    = 12;
   localparam int JAN_IDX   = 10;
   localparam int MARCH_NUM = 3;
   localparam int JAN_NUM   = 1;

   // first day of each month counted from 1 March
   localparam logic [DAW-1:0] MONTH_START [MONTHS] = '{
      9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153,
      9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
   };

endpackage

### rtl/core/julian_date_to_civil_date_core.sv
// ----------------------------------------------------------------------------
// julian_date_to_civil_date_core: Julian date to Gregorian date and time
// Ten-stage pipeline turning a fixed-point Julian date into year, month,
// day, rounded time of day and weekday, with a validity flag.
// ----------------------------------------------------------------------------
// Usage
//   req_ channel: one beat carries req_julian_date, two's complement with
//   FRACTION_BITS fraction bits. A beat is taken on an edge with req_valid
//   high and req_stall low.
//   rsp_ channel: one result beat per request beat, in order. Out-of-range
//   dates (|JD| not below 999999999.99999, or a negative day count) come
//   back with rsp_date_valid low, year 0, 1 January, 00:00:00, weekday 0.
//   Throughput: one beat per cycle while rsp_stall is low, set by the slowest
//   stage (a 30 x 31 bit reciprocal multiply per stage at most).
//   Stall: every stage has its own valid bit and moves up whenever the stage
//   ahead is empty or moving, so bubbles close up; req_stall rises only
//   once all ten stages are full and rsp_stall holds the result register.
//   Reset (synchronous, active high) empties the pipeline; payload
//   registers keep whatever they held.
//   Hour 24 is possible when the day fraction rounds up to a full day; the
//   date is not advanced in that case.
// ----------------------------------------------------------------------------
module julian_date_to_civil_date_core #(
   parameter int FRACTION_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [jdcd_pkg::JD_W-1:0]     req_julian_date,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_date_valid,
   output logic signed [jdcd_pkg::YEAR_W-1:0]   rsp_civil_year,
   output logic        [jdcd_pkg::MONTH_W-1:0]  rsp_civil_month,
   output logic        [jdcd_pkg::DAY_W-1:0]    rsp_civil_day,
   output logic        [jdcd_pkg::HOUR_W-1:0]   rsp_hour_of_day,
   output logic        [jdcd_pkg::MIN_W-1:0]    rsp_minute_of_hour,
   output logic        [jdcd_pkg::SEC_W-1:0]    rsp_second_of_minute,
   output logic        [jdcd_pkg::WDAY_W-1:0]   rsp_weekday
);
   import jdcd_pkg::*;

   // ------------------------------------------------------------------
   // Elaboration constants that follow FRACTION_BITS
   // ------------------------------------------------------------------
   localparam int FB  = FRACTION_BITS;
   localparam int JHW = JD_W + 1;      // date plus half a day
   localparam int SMW = FB + SPW;      // seconds product width

   // smallest fraction that fails the limit: ceil(0.99999 * 2**FB)
   localparam logic [63:0] LIM_FRAC =
      (LIMIT_FRAC_NUM * (64'd1 << FB) + LIMIT_FRAC_DEN - 64'd1) / LIMIT_FRAC_DEN;
   localparam logic [63:0] LIM_MAG  = (LIMIT_DAYS << FB) + LIM_FRAC;
   localparam logic signed [JHW-1:0] HALF_DAY = JHW'(1) << (FB - 1);

   // ------------------------------------------------------------------
   // Beat flow: one valid bit per stage, stage k moves when it is empty
   // or the stage ahead moves. Index STAGES-1 is the result register.
   // ------------------------------------------------------------------
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] rdy;

   always_comb begin
      rdy[STAGES-1] = !vld_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in = {vld_ff[STAGES-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[STAGES-1];

   // ------------------------------------------------------------------
   // Stage 1: capture
   // ------------------------------------------------------------------
   logic signed [JD_W-1:0] s1_jd_ff;

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_jd_ff <= req_julian_date;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: limit check on the magnitude, add half a day
   // ------------------------------------------------------------------
   logic [JD_W-1:0]        s1_mag;
   logic                   s2_lim_in,  s2_lim_ff;
   logic signed [JHW-1:0]  s2_jh_in,   s2_jh_ff;

   always_comb begin
      s1_mag    = s1_jd_ff[JD_W-1] ? (JD_W'(0) - $unsigned(s1_jd_ff))
                                   : $unsigned(s1_jd_ff);
      s2_lim_in = 64'(s1_mag) < LIM_MAG;
      s2_jh_in  = JHW'(s1_jd_ff) + HALF_DAY;
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s2_lim_ff <= s2_lim_in;
         s2_jh_ff  <= s2_jh_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: floor to the day number, day count, day fraction
   // ------------------------------------------------------------------
   logic signed [JHW-1:0] s2_jfull;
   logic                  s3_ok_in,   s3_ok_ff;
   logic [JW-1:0]         s3_j_in,    s3_j_ff;
   logic [FB-1:0]         s3_frac_in, s3_frac_ff;

   always_comb begin
      s2_jfull   = (s2_jh_ff >>> FB) + JHW'(JDN_OFFSET);
      s3_ok_in   = s2_lim_ff && !s2_jfull[JHW-1];
      s3_j_in    = s2_jfull[JW-1:0];
      s3_frac_in = s2_jh_ff[FB-1:0];
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s3_ok_ff   <= s3_ok_in;
         s3_j_ff    <= s3_j_in;
         s3_frac_ff <= s3_frac_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: 400-year quotient, weekday quotient, seconds of day
   // ------------------------------------------------------------------
   logic [JW+G_MW-1:0]  s3_g_prod;
   logic [JW+WK_MW-1:0] s3_wk_prod;
   logic [SMW-1:0]      s3_sec_prod;
   logic                s4_ok_ff;
   logic [JW-1:0]       s4_j_ff;
   logic [GW-1:0]       s4_g_in,    s4_g_ff;
   logic [JW-1:0]       s4_wsum_in, s4_wsum_ff;
   logic [WQW-1:0]      s4_wq_in,   s4_wq_ff;
   logic [SPW-1:0]      s4_secs_in, s4_secs_ff;

   always_comb begin
      s3_g_prod   = (JW+G_MW)'(s3_j_ff) * (JW+G_MW)'(G_MULT);
      s4_g_in     = s3_g_prod[G_SHIFT +: GW];
      s4_wsum_in  = s3_j_ff + JW'(WK_OFFSET);
      s3_wk_prod  = (JW+WK_MW)'(s4_wsum_in) * (JW+WK_MW)'(WK_MULT);
      s4_wq_in    = s3_wk_prod[WK_SHIFT +: WQW];
      // round to the nearest second
      s3_sec_prod = SMW'(s3_frac_ff) * SMW'(SEC_PER_DAY) + (SMW'(1) << (FB - 1));
      s4_secs_in  = s3_sec_prod[FB +: SPW];
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s4_ok_ff   <= s3_ok_ff;
         s4_j_ff    <= s3_j_ff;
         s4_g_ff    <= s4_g_in;
         s4_wsum_ff <= s4_wsum_in;
         s4_wq_ff   <= s4_wq_in;
         s4_secs_ff <= s4_secs_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: day within 400-year cycle, weekday, minutes of day
   // ------------------------------------------------------------------
   logic [JW-1:0]            s4_g_days;
   logic [JW-1:0]            s4_dg_full;
   logic [JW-1:0]            s4_wd_full;
   logic [SPW+M60_MW-1:0]    s4_m60_prod;
   logic                     s5_ok_ff;
   logic [GW-1:0]            s5_g_ff;
   logic [DGW-1:0]           s5_dg_in,   s5_dg_ff;
   logic [WDAY_W-1:0]        s5_wd_in,   s5_wd_ff;
   logic [SPW-1:0]           s5_secs_ff;
   logic [M60W-1:0]          s5_m60_in,  s5_m60_ff;

   always_comb begin
      s4_g_days   = JW'(s4_g_ff) * JW'(DAYS_400Y);
      s4_dg_full  = s4_j_ff - s4_g_days;
      s5_dg_in    = s4_dg_full[DGW-1:0];
      s4_wd_full  = s4_wsum_ff - JW'(s4_wq_ff) * JW'(DAYS_WEEK);
      s5_wd_in    = s4_wd_full[WDAY_W-1:0];
      s4_m60_prod = (SPW+M60_MW)'(s4_secs_ff) * (SPW+M60_MW)'(M60_MULT);
      s5_m60_in   = s4_m60_prod[M60_SHIFT +: M60W];
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s5_ok_ff   <= s4_ok_ff;
         s5_g_ff    <= s4_g_ff;
         s5_dg_ff   <= s5_dg_in;
         s5_wd_ff   <= s5_wd_in;
         s5_secs_ff <= s4_secs_ff;
         s5_m60_ff  <= s5_m60_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: century (the fourth one folds into the third), seconds,
   // hour
   // ------------------------------------------------------------------
   logic [CW-1:0]          s5_c;
   logic [DGW-1:0]         s5_c_days;
   logic [DGW-1:0]         s5_dc_full;
   logic [SPW-1:0]         s5_sec_full;
   logic [M60W+HR_MW-1:0]  s5_hr_prod;
   logic                   s6_ok_ff;
   logic [GW-1:0]          s6_g_ff;
   logic [CW-1:0]          s6_c_ff;
   logic [DCW-1:0]         s6_dc_in,   s6_dc_ff;
   logic [WDAY_W-1:0]      s6_wd_ff;
   logic [M60W-1:0]        s6_m60_ff;
   logic [SEC_W-1:0]       s6_sec_in,  s6_sec_ff;
   logic [HOUR_W-1:0]      s6_hour_in, s6_hour_ff;

   always_comb begin
      if (s5_dg_ff >= DGW'(3 * DAYS_100Y)) begin
         s5_c = CW'(3);
      end else if (s5_dg_ff >= DGW'(2 * DAYS_100Y)) begin
         s5_c = CW'(2);
      end else if (s5_dg_ff >= DGW'(DAYS_100Y)) begin
         s5_c = CW'(1);
      end else begin
         s5_c = CW'(0);
      end
      s5_c_days   = DGW'(s5_c) * DGW'(DAYS_100Y);
      s5_dc_full  = s5_dg_ff - s5_c_days;
      s6_dc_in    = s5_dc_full[DCW-1:0];
      s5_sec_full = s5_secs_ff - SPW'(s5_m60_ff) * SPW'(PER_60);
      s6_sec_in   = s5_sec_full[SEC_W-1:0];
      s5_hr_prod  = (M60W+HR_MW)'(s5_m60_ff) * (M60W+HR_MW)'(HR_MULT);
      s6_hour_in  = s5_hr_prod[HR_SHIFT +: HOUR_W];
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         s6_ok_ff   <= s5_ok_ff;
         s6_g_ff    <= s5_g_ff;
         s6_c_ff    <= s5_c;
         s6_dc_ff   <= s6_dc_in;
         s6_wd_ff   <= s5_wd_ff;
         s6_m60_ff  <= s5_m60_ff;
         s6_sec_ff  <= s6_sec_in;
         s6_hour_ff <= s6_hour_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 7: 4-year cycle quotient, minute
   // ------------------------------------------------------------------
   logic [DCW+B_MW-1:0] s6_b_prod;
   logic [M60W-1:0]     s6_min_full;
   logic                s7_ok_ff;
   logic [GW-1:0]       s7_g_ff;
   logic [CW-1:0]       s7_c_ff;
   logic [DCW-1:0]      s7_dc_ff;
   logic [BW-1:0]       s7_b_in,   s7_b_ff;
   logic [WDAY_W-1:0]   s7_wd_ff;
   logic [SEC_W-1:0]    s7_sec_ff;
   logic [HOUR_W-1:0]   s7_hour_ff;
   logic [MIN_W-1:0]    s7_min_in, s7_min_ff;

   always_comb begin
      s6_b_prod   = (DCW+B_MW)'(s6_dc_ff) * (DCW+B_MW)'(B_MULT);
      s7_b_in     = s6_b_prod[B_SHIFT +: BW];
      s6_min_full = s6_m60_ff - M60W'(s6_hour_ff) * M60W'(PER_60);
      s7_min_in   = s6_min_full[MIN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         s7_ok_ff   <= s6_ok_ff;
         s7_g_ff    <= s6_g_ff;
         s7_c_ff    <= s6_c_ff;
         s7_dc_ff   <= s6_dc_ff;
         s7_b_ff    <= s7_b_in;
         s7_wd_ff   <= s6_wd_ff;
         s7_sec_ff  <= s6_sec_ff;
         s7_hour_ff <= s6_hour_ff;
         s7_min_ff  <= s7_min_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 8: day within 4-year cycle
   // ------------------------------------------------------------------
   logic [DCW-1:0]    s7_db_full;
   logic              s8_ok_ff;
   logic [GW-1:0]     s8_g_ff;
   logic [CW-1:0]     s8_c_ff;
   logic [BW-1:0]     s8_b_ff;
   logic [DBW-1:0]    s8_db_in, s8_db_ff;
   logic [WDAY_W-1:0] s8_wd_ff;
   logic [SEC_W-1:0]  s8_sec_ff;
   logic [HOUR_W-1:0] s8_hour_ff;
   logic [MIN_W-1:0]  s8_min_ff;

   always_comb begin
      s7_db_full = s7_dc_ff - DCW'(s7_b_ff) * DCW'(DAYS_4Y);
      s8_db_in   = s7_db_full[DBW-1:0];
   end

   always_ff @(posedge clock) begin
      if (rdy[7]) begin
         s8_ok_ff   <= s7_ok_ff;
         s8_g_ff    <= s7_g_ff;
         s8_c_ff    <= s7_c_ff;
         s8_b_ff    <= s7_b_ff;
         s8_db_ff   <= s8_db_in;
         s8_wd_ff   <= s7_wd_ff;
         s8_sec_ff  <= s7_sec_ff;
         s8_hour_ff <= s7_hour_ff;
         s8_min_ff  <= s7_min_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 9: year within 4-year cycle (leap day folds into the third),
   // day within March-based year, year count
   // ------------------------------------------------------------------
   logic [AW-1:0]     s8_a;
   logic [DBW-1:0]    s8_da_full;
   logic              s9_ok_ff;
   logic [YW-1:0]     s9_y_in,  s9_y_ff;
   logic [DAW-1:0]    s9_da_in, s9_da_ff;
   logic [WDAY_W-1:0] s9_wd_ff;
   logic [SEC_W-1:0]  s9_sec_ff;
   logic [HOUR_W-1:0] s9_hour_ff;
   logic [MIN_W-1:0]  s9_min_ff;

   always_comb begin
      if (s8_db_ff >= DBW'(3 * DAYS_1Y)) begin
         s8_a = AW'(3);
      end else if (s8_db_ff >= DBW'(2 * DAYS_1Y)) begin
         s8_a = AW'(2);
      end else if (s8_db_ff >= DBW'(DAYS_1Y)) begin
         s8_a = AW'(1);
      end else begin
         s8_a = AW'(0);
      end
      s8_da_full = s8_db_ff - DBW'(s8_a) * DBW'(DAYS_1Y);
      s9_da_in   = s8_da_full[DAW-1:0];
      s9_y_in    = YW'(s8_g_ff) * YW'(YEARS_400) + YW'(s8_c_ff) * YW'(YEARS_100)
                 + YW'(s8_b_ff) * YW'(YEARS_4) + YW'(s8_a);
   end

   always_ff @(posedge clock) begin
      if (rdy[8]) begin
         s9_ok_ff   <= s8_ok_ff;
         s9_y_ff    <= s9_y_in;
         s9_da_ff   <= s9_da_in;
         s9_wd_ff   <= s8_wd_ff;
         s9_sec_ff  <= s8_sec_ff;
         s9_hour_ff <= s8_hour_ff;
         s9_min_ff  <= s8_min_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 10: month from the start table, day of month, civil year;
   // out-of-range beats get the fixed default fields
   // ------------------------------------------------------------------
   logic [MIW-1:0]            s9_mi;
   logic [DAW-1:0]            s9_dom;
   logic                      rsp_date_valid_in,  rsp_date_valid_ff;
   logic signed [YEAR_W-1:0]  rsp_civil_year_in,  rsp_civil_year_ff;
   logic [MONTH_W-1:0]        rsp_civil_month_in, rsp_civil_month_ff;
   logic [DAY_W-1:0]          rsp_civil_day_in,   rsp_civil_day_ff;
   logic [HOUR_W-1:0]         rsp_hour_in,        rsp_hour_ff;
   logic [MIN_W-1:0]          rsp_min_in,         rsp_min_ff;
   logic [SEC_W-1:0]          rsp_sec_in,         rsp_sec_ff;
   logic [WDAY_W-1:0]         rsp_weekday_in,     rsp_weekday_ff;

   always_comb begin
      s9_mi = '0;
      for (int k = 1; k < MONTHS; k++) begin
         if (s9_da_ff >= MONTH_START[k]) begin
            s9_mi = MIW'(k);
         end
      end
      s9_dom = s9_da_ff - MONTH_START[s9_mi];

      rsp_date_valid_in = s9_ok_ff;
      if (s9_ok_ff) begin
         rsp_civil_year_in = YEAR_W'(s9_y_ff) - YEAR_W'(YEAR_BIAS)
                           + ((s9_mi >= MIW'(JAN_IDX)) ? YEAR_W'(1) : YEAR_W'(0));
         if (s9_mi >= MIW'(JAN_IDX)) begin
            rsp_civil_month_in = MONTH_W'(s9_mi) - MONTH_W'(JAN_IDX - JAN_NUM);
         end else begin
            rsp_civil_month_in = MONTH_W'(s9_mi) + MONTH_W'(MARCH_NUM);
         end
         rsp_civil_day_in = DAY_W'(s9_dom) + DAY_W'(1);
         rsp_hour_in      = s9_hour_ff;
         rsp_min_in       = s9_min_ff;
         rsp_sec_in       = s9_sec_ff;
         rsp_weekday_in   = s9_wd_ff;
      end else begin
         rsp_civil_year_in  = '0;
         rsp_civil_month_in = MONTH_W'(JAN_NUM);
         rsp_civil_day_in   = DAY_W'(1);
         rsp_hour_in        = '0;
         rsp_min_in         = '0;
         rsp_sec_in         = '0;
         rsp_weekday_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[STAGES-1]) begin
         rsp_date_valid_ff  <= rsp_date_valid_in;
         rsp_civil_year_ff  <= rsp_civil_year_in;
         rsp_civil_month_ff <= rsp_civil_month_in;
         rsp_civil_day_ff   <= rsp_civil_day_in;
         rsp_hour_ff        <= rsp_hour_in;
         rsp_min_ff         <= rsp_min_in;
         rsp_sec_ff         <= rsp_sec_in;
         rsp_weekday_ff     <= rsp_weekday_in;
      end
   end

   assign rsp_date_valid       = rsp_date_valid_ff;
   assign rsp_civil_year       = rsp_civil_year_ff;
   assign rsp_civil_month      = rsp_civil_month_ff;
   assign rsp_civil_day        = rsp_civil_day_ff;
   assign rsp_hour_of_day      = rsp_hour_ff;
   assign rsp_minute_of_hour   = rsp_min_ff;
   assign rsp_second_of_minute = rsp_sec_ff;
   assign rsp_weekday          = rsp_weekday_ff;

`ifndef SYNTHESIS
   // an empty first stage always takes a beat
   a_entry_free: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[0] |-> !req_stall)
      else $error("req_stall raised with first stage empty");

   // rejected dates carry the fixed default fields
   a_invalid_default: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_date_valid |->
         rsp_civil_year == '0 && rsp_civil_month == MONTH_W'(JAN_NUM) &&
         rsp_civil_day == DAY_W'(1) && rsp_hour_of_day == '0 &&
         rsp_minute_of_hour == '0 && rsp_second_of_minute == '0 &&
         rsp_weekday == '0)
      else $error("invalid beat with non-default fields");

   // calendar and clock fields stay in range
   a_field_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_date_valid |->
         rsp_civil_month >= MONTH_W'(1) && rsp_civil_month <= MONTH_W'(MONTHS) &&
         rsp_civil_day >= DAY_W'(1) && rsp_hour_of_day <= HOUR_W'(24) &&
         rsp_minute_of_hour < MIN_W'(PER_60) && rsp_second_of_minute < SEC_W'(PER_60) &&
         rsp_weekday < WDAY_W'(DAYS_WEEK))
      else $error("result field out of range");

   // hour 24 only from rounding up the last half second of the day
   a_day_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hour_of_day == HOUR_W'(24) |->
         rsp_minute_of_hour == '0 && rsp_second_of_minute == '0)
      else $error("hour 24 with non-zero minute or second");
`endif

endmodule
